// ----- rtl/core/cfts_pkg.sv -----
package cfts_pkg;

	localparam int MARK_LEN     = 12;
	localparam int HIST_LEN     = 11;
	localparam int IGES_COL     = 72;
	localparam int COL_SAT      = 73;
	localparam int STL_HDR      = 84;
	localparam int STL_CNT_AT   = 80;
	localparam int SOLID_LEN    = 5;
	localparam int SIZE_W       = 38;
	localparam int TRI_W        = 32;
	localparam int COL_W        = 7;

	localparam logic [7:0] STEP_MARK [MARK_LEN] = '{
		8'h49, 8'h53, 8'h4F, 8'h2D, 8'h31, 8'h30,
		8'h33, 8'h30, 8'h33, 8'h2D, 8'h32, 8'h31
	};

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_G  = 8'h47;
	localparam logic [7:0] CHAR_F  = 8'h46;

	localparam logic REG_FILE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_STEP    = 2'd1,
		FMT_IGES    = 2'd2,
		FMT_STL     = 2'd3
	} fmt_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic             any;
		logic             step;
		logic             iges;
		logic             solid;
		logic             bin_len;
		logic [TRI_W-1:0] tri_cnt;
	} snap_t;

	function automatic logic [7:0] solid_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h73;
			3'd1:    c = 8'h6F;
			3'd2:    c = 8'h6C;
			3'd3:    c = 8'h69;
			3'd4:    c = 8'h64;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/cfts_cell.sv -----
module cfts_cell #(
	parameter logic [7:0] MARK = 8'h00
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfts_pkg::cell_ctl_t ctl,
	input  logic [7:0]        d_in,
	input  logic              v_in,
	output logic [7:0]        d_out,
	output logic              v_out,
	output logic              match
);
	import cfts_pkg::*;

	logic [7:0] d_q;
	logic       v_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			d_q <= d_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.clear) begin
			v_q <= 1'b0;
		end else if (ctl.shift) begin
			v_q <= v_in;
		end
	end

	assign d_out = d_q;
	assign v_out = v_q;
	assign match = v_q && (d_q == MARK);

endmodule

// ----- rtl/core/cfts_track.sv -----
module cfts_track #(
	parameter int HEAD_BYTES    = 4096,
	parameter int LINES_CHECKED = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                end_only,
	input  logic                step_hit,
	output cfts_pkg::cell_ctl_t ctl,
	output logic                done,
	output cfts_pkg::snap_t     snap
);
	import cfts_pkg::*;

	localparam int PW = $clog2(HEAD_BYTES + 1);
	localparam int LW = $clog2(LINES_CHECKED + 1);

	logic [PW-1:0]    pos_q, pos_n;
	logic [LW-1:0]    line_q, line_n;
	logic [COL_W-1:0] col_q, col_n;
	logic             step_q, step_n;
	logic             iges_q, iges_n;
	logic             solid_q, solid_n;
	logic [TRI_W-1:0] tri_q, tri_n;
	logic             take;
	logic             is_letter;

	assign take      = acc && !end_only && (pos_q < PW'(HEAD_BYTES));
	assign done      = acc && (end_only || last_byte);
	assign is_letter = (data_byte == CHAR_S) || (data_byte == CHAR_G) || (data_byte == CHAR_F);

	always_comb begin
		pos_n   = pos_q;
		line_n  = line_q;
		col_n   = col_q;
		step_n  = step_q;
		iges_n  = iges_q;
		solid_n = solid_q;
		tri_n   = tri_q;
		if (take) begin
			pos_n = pos_q + PW'(1);
			if (step_hit) begin
				step_n = 1'b1;
			end
			if ((line_q < LW'(LINES_CHECKED)) && (col_q == COL_W'(IGES_COL)) && is_letter) begin
				iges_n = 1'b1;
			end
			if (data_byte == CHAR_NL) begin
				if (line_q < LW'(LINES_CHECKED)) begin
					line_n = line_q + LW'(1);
				end
				col_n = '0;
			end else if (col_q < COL_W'(COL_SAT)) begin
				col_n = col_q + COL_W'(1);
			end
			if ((pos_q < PW'(SOLID_LEN)) && (data_byte != solid_char(pos_q[2:0]))) begin
				solid_n = 1'b0;
			end
			if ((pos_q >= PW'(STL_CNT_AT)) && (pos_q < PW'(STL_HDR))) begin
				tri_n[{pos_q[1:0], 3'b000} +: 8] = data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			line_q  <= '0;
			col_q   <= '0;
			step_q  <= 1'b0;
			iges_q  <= 1'b0;
			solid_q <= 1'b1;
			tri_q   <= '0;
		end else if (done) begin
			pos_q   <= '0;
			line_q  <= '0;
			col_q   <= '0;
			step_q  <= 1'b0;
			iges_q  <= 1'b0;
			solid_q <= 1'b1;
			tri_q   <= '0;
		end else begin
			pos_q   <= pos_n;
			line_q  <= line_n;
			col_q   <= col_n;
			step_q  <= step_n;
			iges_q  <= iges_n;
			solid_q <= solid_n;
			tri_q   <= tri_n;
		end
	end

	assign ctl.shift = take;
	assign ctl.clear = done;

	assign snap.any     = (pos_n != '0);
	assign snap.step    = step_n;
	assign snap.iges    = iges_n;
	assign snap.solid   = solid_n && (pos_n >= PW'(SOLID_LEN));
	assign snap.bin_len = (pos_n >= PW'(STL_HDR));
	assign snap.tri_cnt = tri_n;

endmodule

// ----- rtl/core/cad_file_type_sniffer_core.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------
// in       | in_valid / in_ready    | data_byte, last_byte, end_only
// out      | out_valid / out_ready  | format_code
// cfg      | APB psel/penable/pready| paddr, pwdata, prdata (file_size)
//
// One byte per cycle unless in_ready drops; eleven history cells shift per data byte in the head.
// The ending transfer fills the snapshot stage; the code is then decided and registered.
// in_ready drops only while the snapshot stage is full and the output stalls.
// Reset clears scan counters, flags, cell valid bits and file_size; scan state clears at each end.
module cad_file_type_sniffer_core #(
	parameter int HEAD_BYTES    = 4096,
	parameter int LINES_CHECKED = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        end_only,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  format_code
);
	import cfts_pkg::*;

	logic [SIZE_W-1:0] file_size_q;
	logic              acc;
	logic              done;
	logic              step_hit;
	cell_ctl_t         ctl;
	snap_t             snap;
	snap_t             snap_s1;
	logic              vld_s1;
	logic              out_adv;
	logic              out_valid_q;
	fmt_t              fmt_q;
	fmt_t              fmt_d;
	logic [SIZE_W-1:0] stl_size;
	logic [7:0]        hist_d [HIST_LEN+1];
	logic              hist_v [HIST_LEN+1];
	logic [HIST_LEN-1:0] cell_match;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (psel && penable && pwrite && (paddr[3] == REG_FILE_SIZE)) begin
			file_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[3] == REG_FILE_SIZE) begin
			prdata = {{(64-SIZE_W){1'b0}}, file_size_q};
		end
	end

	assign out_adv  = !out_valid_q || out_ready;
	assign in_ready = !vld_s1 || out_adv;
	assign acc      = in_valid && in_ready;

	assign hist_d[0] = data_byte;
	assign hist_v[0] = 1'b1;

	for (genvar k = 0; k < HIST_LEN; k++) begin : g_cell
		cfts_cell #(
			.MARK(STEP_MARK[MARK_LEN-2-k])
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.d_in  (hist_d[k]),
			.v_in  (hist_v[k]),
			.d_out (hist_d[k+1]),
			.v_out (hist_v[k+1]),
			.match (cell_match[k])
		);
	end

	assign step_hit = (data_byte == STEP_MARK[MARK_LEN-1]) && (&cell_match);

	cfts_track #(
		.HEAD_BYTES   (HEAD_BYTES),
		.LINES_CHECKED(LINES_CHECKED)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.end_only (end_only),
		.step_hit (step_hit),
		.ctl      (ctl),
		.done     (done),
		.snap     (snap)
	);

	always_ff @(posedge clk) begin
		if (done) begin
			snap_s1 <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (done) begin
			vld_s1 <= 1'b1;
		end else if (out_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	assign stl_size = SIZE_W'(STL_HDR)
		+ {1'b0, snap_s1.tri_cnt, 5'b00000}
		+ {2'b00, snap_s1.tri_cnt, 4'b0000}
		+ {5'b00000, snap_s1.tri_cnt, 1'b0};

	always_comb begin
		fmt_d = FMT_UNKNOWN;
		if (!snap_s1.any) begin
			fmt_d = FMT_UNKNOWN;
		end else if (snap_s1.step) begin
			fmt_d = FMT_STEP;
		end else if (snap_s1.iges) begin
			fmt_d = FMT_IGES;
		end else if (snap_s1.solid) begin
			fmt_d = FMT_STL;
		end else if (snap_s1.bin_len && (file_size_q == stl_size)) begin
			fmt_d = FMT_STL;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && out_adv) begin
			fmt_q <= fmt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= vld_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign format_code = fmt_q;

	a_snap_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_adv |=> out_valid_q)
		else $error("snapshot lost on way to output");

	a_end_to_snap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_only |=> vld_s1)
		else $error("ending transfer did not fill snapshot stage");

	a_step_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && snap_s1.step |-> snap_s1.any)
		else $error("step mark seen with no bytes taken");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !hist_v[1])
		else $error("history cells not cleared after end");

endmodule
